// ----- rtl/fsr_pkg.sv -----
`timescale 1ns / 1ps
// fsr_pkg: codes and fixed widths of the fractional shift resampler
// no dependencies

package fsr_pkg;

   // request kinds
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   // operating modes
   localparam logic [1:0] OP_FORWARD    = 2'd0;
   localparam logic [1:0] OP_INPUT_GRAD = 2'd1;
   localparam logic [1:0] OP_SHIFT_GRAD = 2'd2;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_AMOUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_AMOUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_LENGTH = 3'd4;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned POS_W      = 10;
   localparam int unsigned SHIFT_W    = 16;
   localparam int unsigned PAD_W      = 8;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned LEN_W      = 11;
   localparam int unsigned DIFF_W     = 16;
   localparam int unsigned RESULT_W   = 32;

   // signed tap index, covers position*stride, the pad and the integer shift
   localparam int unsigned IDX_W = 17;
   // dividend bits of the input-gradient tap index
   localparam int unsigned DIV_BITS = 11;
   localparam int unsigned DIV_CNT_W = 4;

endpackage

// ----- rtl/fractional_shift_resampler_1d.sv -----
`timescale 1ns / 1ps
// fractional_shift_resampler_1d: row store plus fractional shift sampler
// depends on fsr_pkg
//
// Usage
//  - req channel (valid/ready) carries one transaction per request: a load
//    writes req_sample_value at req_position into the row store, a compute
//    asks for one result at output index req_position
//  - rsp channel (valid/ready) returns one transaction per compute request
//  - csr port writes the mode, shift, pad, stride and length registers
//  - a load leaves req_ready high; a compute holds req_ready low from acceptance
//    until its result enters the output register, through the address, tap,
//    two read, capture, multiply and output steps; the unused mode goes from
//    address straight to output, and input-gradient mode adds a serial divide
//    by the stride to place the taps unless the tap origin is negative; one memory
//    port does the two tap reads and one shared multiplier does the weighting
//  - the output register frees the request side: loads and the next compute
//    are taken while a result waits on a stalled receiver, but a finished
//    compute waits in its last step until the register is free
//  - reset sets the registers to forward mode, zero shift and pad, stride 1,
//    full length; the row store is not cleared and holds garbage until loaded

module fractional_shift_resampler_1d
   import fsr_pkg::*;
#(
   parameter int unsigned MAX_WIDTH   = 1024,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [POS_W-1:0]              req_position,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  logic signed [DIFF_W-1:0]      req_diff_value,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [RESULT_W-1:0]    rsp_result_value,
   output logic [POS_W-1:0]              rsp_result_position,

   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int unsigned ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned MA_W    = SAMPLE_BITS + 1;
   localparam int unsigned MB_W    = DIFF_W + 1;
   localparam int unsigned ACC_W   = MA_W + MB_W;
   localparam int unsigned WIDE_W  = ACC_W + RESULT_W;
   localparam logic [IDX_W-1:0] LenMax = IDX_W'(MAX_WIDTH);

   typedef enum logic [3:0] {
      S_IDLE, S_ADDR, S_TAPS, S_DIV, S_RD_A, S_RD_B, S_CAP_B, S_MUL1, S_MUL2, S_OUT
   } state_type;

   state_type                   state_ff;

   logic [1:0]                  op_mode_ff;
   logic signed [SHIFT_W-1:0]   shift_ff;
   logic [PAD_W-1:0]            pad_ff;
   logic [STEP_W-1:0]           stride_ff;
   logic [LEN_W-1:0]            length_ff;

   logic [POS_W-1:0]            pos_ff;
   logic signed [DIFF_W-1:0]    diff_ff;
   logic [7:0]                  frac_ff;
   logic signed [IDX_W-1:0]     w_ff;
   logic signed [IDX_W-1:0]     tap_a_ff;
   logic signed [IDX_W-1:0]     tap_b_ff;
   logic                        tap_a_ok_ff;
   logic                        tap_b_ok_ff;
   logic [STEP_W-1:0]           div_rem_ff;
   logic [DIV_BITS-1:0]         div_quo_ff;
   logic [DIV_CNT_W-1:0]        div_cnt_ff;
   logic signed [SAMPLE_BITS-1:0] q1_ff;
   logic signed [SAMPLE_BITS-1:0] q2_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic                        rsp_valid_ff;
   logic signed [RESULT_W-1:0]  rsp_value_ff;
   logic [POS_W-1:0]            rsp_pos_ff;

   logic signed [SAMPLE_BITS-1:0] row_store [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   logic                        req_fire;
   logic                        load_wr;
   logic [ADDR_W-1:0]           rd_addr;
   logic [STEP_W-1:0]           stride_eff;
   logic [IDX_W-1:0]            len_eff;
   logic signed [SHIFT_W-1:0]   shift_neg;
   logic signed [SHIFT_W-1:0]   shift_sel;
   logic signed [IDX_W-1:0]     x1_ext;
   logic [13:0]                 pos_mul_stride;
   logic signed [IDX_W-1:0]     w_in;
   logic [STEP_W:0]             div_shifted;
   logic                        div_bit;
   logic [STEP_W-1:0]           div_rem_in;
   logic [DIV_BITS-1:0]         div_quo_in;
   logic signed [MA_W-1:0]      mul_a;
   logic signed [MB_W-1:0]      mul_b;
   logic signed [ACC_W-1:0]     mul_p;
   logic signed [ACC_W-1:0]     acc_out;
   logic signed [WIDE_W-1:0]    acc_wide;

   function automatic logic tap_in_range(input logic signed [IDX_W-1:0] idx,
                                         input logic [IDX_W-1:0] len);
      return !idx[IDX_W-1] && ($unsigned(idx) < len);
   endfunction

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign load_wr   = req_fire && (req_type == REQ_LOAD) && (IDX_W'(req_position) < LenMax);

   assign stride_eff = (stride_ff == '0) ? STEP_W'(1) : stride_ff;
   assign len_eff    = (IDX_W'(length_ff) > LenMax) ? LenMax : IDX_W'(length_ff);

   // tap origin from position, stride, pad and integer part of the shift
   assign shift_neg  = (shift_ff == {1'b1, {(SHIFT_W-1){1'b0}}}) ?
                       {1'b0, {(SHIFT_W-1){1'b1}}} : -shift_ff;
   assign shift_sel  = (op_mode_ff == OP_INPUT_GRAD) ? shift_neg : shift_ff;
   assign x1_ext     = IDX_W'($signed(shift_sel[SHIFT_W-1:8]));
   assign pos_mul_stride = 14'(pos_ff) * 14'(stride_eff);
   always_comb begin
      if (op_mode_ff == OP_INPUT_GRAD) begin
         w_in = $signed(IDX_W'(pos_ff)) + $signed(IDX_W'(pad_ff)) + x1_ext;
      end else begin
         w_in = $signed(IDX_W'(pos_mul_stride)) - $signed(IDX_W'(pad_ff)) + x1_ext;
      end
   end

   // one restoring divide step per cycle
   assign div_shifted = {div_rem_ff, div_quo_ff[DIV_BITS-1]};
   assign div_bit     = (div_shifted >= {1'b0, stride_eff});
   assign div_rem_in  = div_bit ? STEP_W'(div_shifted - {1'b0, stride_eff})
                                : STEP_W'(div_shifted);
   assign div_quo_in  = {div_quo_ff[DIV_BITS-2:0], div_bit};

   // shared multiplier
   always_comb begin
      if (state_ff == S_MUL2) begin
         mul_a = MA_W'(q2_ff);
         mul_b = $signed({{(MB_W-8){1'b0}}, frac_ff});
      end else if (op_mode_ff == OP_SHIFT_GRAD) begin
         mul_a = MA_W'(q2_ff) - MA_W'(q1_ff);
         mul_b = MB_W'(diff_ff);
      end else begin
         mul_a = MA_W'(q1_ff);
         mul_b = $signed({{(MB_W-9){1'b0}}, 9'd256 - {1'b0, frac_ff}});
      end
   end
   assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

   assign acc_out  = (op_mode_ff == OP_SHIFT_GRAD) ? acc_ff : (acc_ff >>> 8);
   assign acc_wide = WIDE_W'(acc_out);

   assign rd_addr = (state_ff == S_RD_A) ? ADDR_W'(tap_a_ff) : ADDR_W'(tap_b_ff);

   always_ff @(posedge clock) begin
      if (load_wr) begin
         row_store[ADDR_W'(req_position)] <= req_sample_value;
      end
      rd_data_ff <= row_store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_mode_ff   <= OP_FORWARD;
         shift_ff     <= '0;
         pad_ff       <= '0;
         stride_ff    <= STEP_W'(1);
         length_ff    <= LEN_W'(1024);
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_OP_MODE:       op_mode_ff <= csr_wdata[1:0];
               CSR_SHIFT_AMOUNT:  shift_ff   <= $signed(csr_wdata[SHIFT_W-1:0]);
               CSR_PAD_AMOUNT:    pad_ff     <= csr_wdata[PAD_W-1:0];
               CSR_STRIDE_STEP:   stride_ff  <= csr_wdata[STEP_W-1:0];
               CSR_SOURCE_LENGTH: length_ff  <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_type == REQ_COMPUTE)) begin
                  pos_ff   <= req_position;
                  diff_ff  <= req_diff_value;
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR: begin
               w_ff    <= w_in;
               frac_ff <= shift_sel[7:0];
               if (op_mode_ff == OP_INPUT_GRAD || op_mode_ff == OP_FORWARD ||
                   op_mode_ff == OP_SHIFT_GRAD) begin
                  state_ff <= S_TAPS;
               end else begin
                  acc_ff   <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_TAPS: begin
               if (op_mode_ff == OP_INPUT_GRAD) begin
                  if (w_ff[IDX_W-1]) begin
                     tap_a_ok_ff <= 1'b0;
                     tap_b_ff    <= '0;
                     tap_b_ok_ff <= (w_ff == -IDX_W'(1));
                     state_ff    <= S_RD_A;
                  end else begin
                     div_rem_ff <= '0;
                     div_quo_ff <= DIV_BITS'(w_ff);
                     div_cnt_ff <= '0;
                     state_ff   <= S_DIV;
                  end
               end else begin
                  // zero fraction in shift-gradient mode takes the tap one left
                  tap_a_ff    <= (op_mode_ff == OP_SHIFT_GRAD && frac_ff == '0) ?
                                 w_ff - IDX_W'(1) : w_ff;
                  tap_b_ff    <= w_ff + IDX_W'(1);
                  tap_a_ok_ff <= 1'b1;
                  tap_b_ok_ff <= 1'b1;
                  state_ff    <= S_RD_A;
               end
            end
            S_DIV: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= div_quo_in;
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
                  tap_a_ff    <= $signed(IDX_W'(div_quo_in));
                  tap_a_ok_ff <= (div_rem_in == '0);
                  tap_b_ff    <= $signed(IDX_W'(div_quo_in) + IDX_W'(1));
                  tap_b_ok_ff <= (({1'b0, div_rem_in} + (STEP_W+1)'(1)) ==
                                  {1'b0, stride_eff});
                  state_ff    <= S_RD_A;
               end
            end
            S_RD_A: begin
               tap_a_ok_ff <= tap_a_ok_ff && tap_in_range(tap_a_ff, len_eff);
               state_ff    <= S_RD_B;
            end
            S_RD_B: begin
               q1_ff       <= tap_a_ok_ff ? rd_data_ff : '0;
               tap_b_ok_ff <= tap_b_ok_ff && tap_in_range(tap_b_ff, len_eff);
               state_ff    <= S_CAP_B;
            end
            S_CAP_B: begin
               q2_ff    <= tap_b_ok_ff ? rd_data_ff : '0;
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               acc_ff   <= mul_p;
               state_ff <= (op_mode_ff == OP_SHIFT_GRAD) ? S_OUT : S_MUL2;
            end
            S_MUL2: begin
               acc_ff   <= acc_ff + mul_p;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= acc_wide[RESULT_W-1:0];
                  rsp_pos_ff   <= pos_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = rsp_value_ff;
   assign rsp_result_position = rsp_pos_ff;

   // a new result only comes out of the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   // a load never starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_LOAD) |=> (state_ff == S_IDLE))
      else $error("load left the idle state");

   // a compute always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_COMPUTE) |=> (state_ff == S_ADDR))
      else $error("compute not started");

   // the divider never runs past its dividend width
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff < DIV_CNT_W'(DIV_BITS)))
      else $error("divide step count overrun");

   // a pending result is not overwritten while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("stalled result changed");

endmodule

// ----- sim/fractional_shift_resampler_1d_tb.sv -----
`timescale 1ns / 1ps
// fractional_shift_resampler_1d_tb: self-checking bench for the fractional shift resampler
// depends on fsr_pkg and fractional_shift_resampler_1d; predicts every result and checks it

module fractional_shift_resampler_1d_tb;
   import fsr_pkg::*;

   localparam int ROW_DEPTH = 1024;
   localparam int SAMPLE_W  = 16;
   localparam int HOLD_CYCLES = 300;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic signed [RESULT_W-1:0] value;
      logic [POS_W-1:0]           position;
   } resample_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = REQ_LOAD;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic signed [DIFF_W-1:0]   req_diff_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_result_value;
   logic [POS_W-1:0]           rsp_result_position;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // shadow of the block: row contents and register settings
   logic signed [SAMPLE_W-1:0] row_mem [0:ROW_DEPTH-1];
   logic [1:0]                 mode_q   = OP_FORWARD;
   logic signed [SHIFT_W-1:0]  shift_q  = '0;
   logic [PAD_W-1:0]           pad_q    = '0;
   logic [STEP_W-1:0]          stride_q = 4'd1;
   logic [LEN_W-1:0]           len_q    = 11'd1024;

   resample_type resampled_q[$];

   logic rx_hold = 1'b0;
   event hold_kick;

   int tx_max_gap = 8;
   int rx_max_stall = 8;
   int stall_left = 0;
   int loads_sent = 0;
   int computes_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int failures = 0;

   fractional_shift_resampler_1d u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_position        (req_position),
      .req_sample_value    (req_sample_value),
      .req_diff_value      (req_diff_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_value    (rsp_result_value),
      .rsp_result_position (rsp_result_position),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[fractional_shift_resampler_1d] ERROR");
      $finish;
   end

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= 10)
         $display("%s", msg);
   endfunction

   function automatic longint row_limit();
      return (len_q > 11'd1024) ? longint'(ROW_DEPTH) : longint'(len_q);
   endfunction

   function automatic longint row_tap(longint idx);
      if (idx < 0 || idx >= row_limit())
         return 0;
      return longint'(row_mem[idx]);
   endfunction

   function automatic longint strided_tap(longint w, longint stride);
      if (w < 0 || (w % stride) != 0)
         return 0;
      return row_tap(w / stride);
   endfunction

   function automatic longint blend(longint q1, longint q2, longint f);
      return (q1 * (256 - f) + q2 * f) >>> 8;
   endfunction

   function automatic longint negated_shift();
      longint s;
      s = -longint'(shift_q);
      if (s > 32767)
         s = 32767;
      return s;
   endfunction

   // interpolated sample or gradient product for one compute transaction
   function automatic logic signed [RESULT_W-1:0] resample_at(logic [POS_W-1:0] pos,
                                                              logic signed [DIFF_W-1:0] diff);
      longint s, x1, f, w1, stride, q1, q2, q1a, res;
      stride = (stride_q == 0) ? 1 : longint'(stride_q);
      res = 0;
      case (mode_q)
         OP_FORWARD, OP_SHIFT_GRAD: begin
            s  = longint'(shift_q);
            x1 = s >>> 8;
            f  = s & 255;
            w1 = longint'(pos) * stride - longint'(pad_q) + x1;
            q1 = row_tap(w1);
            q2 = row_tap(w1 + 1);
            if (mode_q == OP_FORWARD) begin
               res = blend(q1, q2, f);
            end else begin
               q1a = (f == 0) ? row_tap(w1 - 1) : q1;
               res = (q2 - q1a) * longint'(diff);
            end
         end
         OP_INPUT_GRAD: begin
            s  = negated_shift();
            x1 = s >>> 8;
            f  = s & 255;
            w1 = longint'(pos) + longint'(pad_q) + x1;
            res = blend(strided_tap(w1, stride), strided_tap(w1 + 1, stride), f);
         end
         default: res = 0;
      endcase
      return res[RESULT_W-1:0];
   endfunction

   // output index whose taps mostly land inside the valid row
   function automatic logic [POS_W-1:0] aim_position();
      longint lim, stride, num;
      lim = row_limit();
      stride = (stride_q == 0) ? 1 : longint'(stride_q);
      if (lim == 0 || $urandom_range(0, 3) == 0)
         return POS_W'($urandom_range(0, 1023));
      if (mode_q == OP_INPUT_GRAD) begin
         num = longint'($urandom_range(0, lim - 1)) * stride - longint'(pad_q)
               - (negated_shift() >>> 8);
      end else begin
         num = longint'($urandom_range(0, lim - 1)) + longint'(pad_q)
               - (longint'(shift_q) >>> 8);
         num = (num < 0) ? -1 : num / stride;
      end
      if (num < 0 || num > 1023)
         return POS_W'($urandom_range(0, 1023));
      return POS_W'(num);
   endfunction

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 15))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // one transaction on the request side, shadow updated on acceptance
   task automatic send_request(logic kind, logic [POS_W-1:0] pos,
                               logic signed [SAMPLE_W-1:0] sample,
                               logic signed [DIFF_W-1:0] diff);
      int gap;
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_position     <= pos;
      req_sample_value <= sample;
      req_diff_value   <= diff;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == REQ_LOAD) begin
         row_mem[pos] = sample;
         loads_sent++;
      end else begin
         resampled_q.push_back('{value: resample_at(pos, diff), position: pos});
         computes_sent++;
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (resampled_q.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OP_MODE:       mode_q   = data[1:0];
         CSR_SHIFT_AMOUNT:  shift_q  = data;
         CSR_PAD_AMOUNT:    pad_q    = data[PAD_W-1:0];
         CSR_STRIDE_STEP:   stride_q = data[STEP_W-1:0];
         CSR_SOURCE_LENGTH: len_q    = data[LEN_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_settings(logic [1:0] mode, logic [15:0] shift, logic [7:0] pad,
                                 logic [3:0] stride, logic [10:0] len);
      write_register(CSR_OP_MODE, CSR_DATA_W'(mode));
      write_register(CSR_SHIFT_AMOUNT, shift);
      write_register(CSR_PAD_AMOUNT, CSR_DATA_W'(pad));
      write_register(CSR_STRIDE_STEP, CSR_DATA_W'(stride));
      write_register(CSR_SOURCE_LENGTH, CSR_DATA_W'(len));
   endtask

   // long receiver hold, counted here while the sender keeps offering
   always begin : rx_hold_ctl
      @(hold_kick);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // response side: random stalls, long hold on request, in-order check
   always @(posedge clock) begin : rsp_side
      resample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (resampled_q.size() == 0) begin
            note_failure($sformatf("unexpected result at position %0d value %0d",
                                   rsp_result_position, rsp_result_value));
         end else begin
            want = resampled_q.pop_front();
            if (rsp_result_value !== want.value || rsp_result_position !== want.position)
               note_failure($sformatf("mismatch: position exp %0d got %0d, value exp %0d got %0d",
                                      want.position, rsp_result_position,
                                      want.value, rsp_result_value));
         end
         stall_left = $urandom_range(0, rx_max_stall);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      if (rx_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (stall_left == 0);
      end
   end

   task automatic test_row_fill();
      int i;
      tx_max_gap = 0;
      for (i = 0; i < ROW_DEPTH; i++) begin
         if (i == 256)
            tx_max_gap = 8;
         send_request(REQ_LOAD, POS_W'(i), random_word(), random_word());
      end
      settle_block();
   endtask

   task automatic test_forward_directed();
      apply_settings(OP_FORWARD, 16'h0080, 8'd0, 4'd1, 11'd1024);
      send_request(REQ_LOAD, 10'd10, 16'sh7fff, 16'h0000);
      send_request(REQ_LOAD, 10'd11, 16'sh8000, 16'hffff);
      send_request(REQ_COMPUTE, 10'd10, 16'h0000, 16'h0000);
      send_request(REQ_COMPUTE, 10'd1023, 16'hffff, 16'h0000);
      send_request(REQ_COMPUTE, 10'd0, 16'h0000, 16'hffff);
      settle_block();
   endtask

   task automatic test_input_grad_directed();
      // negated shift saturates
      apply_settings(OP_INPUT_GRAD, 16'h8000, 8'd0, 4'd1, 11'd1024);
      send_request(REQ_COMPUTE, 10'd0, 16'h0000, 16'h0000);
      send_request(REQ_COMPUTE, 10'd896, 16'h0000, 16'h0000);
      settle_block();
      apply_settings(OP_INPUT_GRAD, 16'h0100, 8'd255, 4'd3, 11'd1024);
      send_request(REQ_COMPUTE, 10'd1, 16'h0000, 16'h0000);
      send_request(REQ_COMPUTE, 10'd1023, 16'h0000, 16'h0000);
      settle_block();
      // zero stride
      apply_settings(OP_INPUT_GRAD, 16'h0040, 8'd0, 4'd0, 11'd1024);
      send_request(REQ_COMPUTE, 10'd5, 16'h0000, 16'h0000);
      settle_block();
   endtask

   task automatic test_shift_grad_directed();
      apply_settings(OP_SHIFT_GRAD, 16'h0000, 8'd0, 4'd1, 11'd1024);
      send_request(REQ_LOAD, 10'd9, 16'sh7fff, 16'h0000);
      send_request(REQ_COMPUTE, 10'd10, 16'h0000, 16'sh8000);
      send_request(REQ_COMPUTE, 10'd0, 16'h0000, 16'sh7fff);
      settle_block();
      apply_settings(OP_SHIFT_GRAD, 16'h0140, 8'd2, 4'd8, 11'd1024);
      send_request(REQ_COMPUTE, 10'd3, 16'h0000, random_word());
      settle_block();
   endtask

   task automatic test_unused_mode();
      apply_settings(OP_UNUSED, 16'h0123, 8'd3, 4'd2, 11'd1024);
      send_request(REQ_COMPUTE, 10'd4, 16'h0000, 16'h1111);
      settle_block();
   endtask

   task automatic test_length_limits();
      // length beyond the store, then empty row, then single sample
      apply_settings(OP_FORWARD, 16'h7fff, 8'd0, 4'd1, 11'd2047);
      send_request(REQ_COMPUTE, 10'd0, 16'h0000, 16'h0000);
      send_request(REQ_COMPUTE, 10'd1023, 16'h0000, 16'h0000);
      settle_block();
      apply_settings(OP_FORWARD, 16'h0000, 8'd0, 4'd1, 11'd0);
      send_request(REQ_COMPUTE, 10'd5, 16'h0000, 16'h0000);
      settle_block();
      apply_settings(OP_SHIFT_GRAD, 16'hff00, 8'd0, 4'd1, 11'd1);
      send_request(REQ_COMPUTE, 10'd0, 16'h0000, 16'h1234);
      send_request(REQ_COMPUTE, 10'd1, 16'h0000, 16'sh7fff);
      settle_block();
   endtask

   task automatic test_random_settings(int phases, int per_phase);
      logic [1:0]  mode;
      logic [15:0] shift;
      logic [7:0]  pad;
      logic [3:0]  stride;
      logic [10:0] len;
      int pick;
      int ph;
      int k;
      for (ph = 0; ph < phases; ph++) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 3) ? OP_FORWARD : (pick < 6) ? OP_INPUT_GRAD :
                (pick < 9) ? OP_SHIFT_GRAD : OP_UNUSED;
         case ($urandom_range(0, 3))
            0: shift = 16'($urandom);
            1: shift = 16'($urandom_range(0, 2047)) - 16'd1024;
            2: shift = {8'($urandom_range(0, 16)) - 8'd8, 8'h00};
            default: shift = random_word();
         endcase
         pad = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
         stride = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
         case ($urandom_range(0, 5))
            0: len = 11'($urandom);
            1: len = 11'($urandom_range(1, 64));
            default: len = 11'($urandom_range(1, 1024));
         endcase
         apply_settings(mode, shift, pad, stride, len);
         tx_max_gap   = (ph % 4 == 1 || ph % 4 == 3) ? 0 : 8;
         rx_max_stall = (ph % 4 == 3) ? 0 : 8;
         for (k = 0; k < per_phase; k++) begin
            if ($urandom_range(0, 3) == 0)
               send_request(REQ_LOAD, POS_W'($urandom_range(0, 1023)), random_word(),
                            random_word());
            else
               send_request(REQ_COMPUTE, aim_position(), random_word(), random_word());
         end
         settle_block();
      end
      tx_max_gap = 8;
      rx_max_stall = 8;
   endtask

   task automatic test_input_stall();
      int i;
      apply_settings(OP_FORWARD, 16'h0080, 8'd0, 4'd1, 11'd1024);
      tx_max_gap = 0;
      -> hold_kick;
      for (i = 0; i < 30; i++)
         send_request((i % 3 == 0) ? REQ_LOAD : REQ_COMPUTE, aim_position(), random_word(),
                      random_word());
      tx_max_gap = 8;
      settle_block();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_row_fill();
      test_forward_directed();
      test_input_grad_directed();
      test_shift_grad_directed();
      test_unused_mode();
      test_length_limits();
      test_random_settings(10, 50);
      test_input_stall();
      $display("run covered %0d row loads and %0d computes over all modes, %0d register writes",
               loads_sent, computes_sent, csr_writes);
      $display("%0d results compared, %0d mismatches", results_checked, failures);
      if (failures == 0 && resampled_q.size() == 0)
         $display("[fractional_shift_resampler_1d] OK");
      else
         $display("[fractional_shift_resampler_1d] ERROR");
      $finish;
   end

endmodule
